/* rtl/button_debounce_long_press_defines.svh */
// ----------------------------------------------------------------------------
// button debounce long press: assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

`ifndef ASSERT_OFF
`define BDLP_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BDLP_ASSERT_ALWAYS(name, prop, clk) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define BDLP_ASSERT(name, prop, clk, rst_n)
`define BDLP_ASSERT_ALWAYS(name, prop, clk)
`endif

`endif

/* rtl/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg
// types and constants shared by the button debounce long press block
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;

  // event codes
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvShort = 2'd1;
  localparam logic [1:0] EvLong  = 2'd2;

  // register indexes
  localparam logic RegDebounce  = 1'b0;
  localparam logic RegLongPress = 1'b1;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst = 16'd1000;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] press_event;
    logic       stable_level;
    logic       held;
  } out_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
  } cfg_t;

endpackage

/* rtl/button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press
// debounces an active-low button and reports short and long presses
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_ready_o / in_data_i) carries one button
//   sample with its millisecond timestamp per transaction
//   output channel (out_valid_o / out_ready_i / out_data_o) returns one
//   result per sample: press event, debounced level and held flag
//   apb port sets debounce_ms (0x0) and long_press_ms (0x4), 16 bits each
// path: each result is registered behind its input transaction
//   (input register, then result register)
// throughput: one sample per cycle while results are taken; the state update
//   is a single pass of two 32-bit subtractions and compares between the two registers
// reset: debounced level released, times zero, no press held,
//   debounce_ms 50, long_press_ms 1000, both channels empty
// stall: a held result keeps its register; one more sample waits in the
//   input register and in_ready_o drops until the result is taken
// ----------------------------------------------------------------------------
module button_debounce_long_press (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bdlp_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bdlp_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdlp_pkg::AddrW-1:0]  paddr,
  input  logic [bdlp_pkg::DataW-1:0]  pwdata,
  output logic [bdlp_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import bdlp_pkg::*;

  in_t  in_q;
  logic in_valid_q, in_valid_d;
  out_t out_q;
  out_t res;
  logic out_valid_q, out_valid_d;
  logic adv;
  logic in_acc;
  cfg_t cfg_q;
  logic reg_idx;
  logic cfg_wr;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign in_valid_d  = in_acc ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      RegDebounce:  prdata = {{(DataW-CfgW){1'b0}}, cfg_q.debounce_ms};
      RegLongPress: prdata = {{(DataW-CfgW){1'b0}}, cfg_q.long_press_ms};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.long_press_ms <= LongPressRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegDebounce:  cfg_q.debounce_ms   <= pwdata[CfgW-1:0];
        RegLongPress: cfg_q.long_press_ms <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  bdlp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .smp_i  (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

endmodule

/* rtl/bdlp_core.sv */
// ----------------------------------------------------------------------------
// bdlp_core
// debounce state and short / long press classification for one sample
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_defines.svh"

module bdlp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  bdlp_pkg::in_t  smp_i,
  input  bdlp_pkg::cfg_t cfg_i,
  output bdlp_pkg::out_t res_o
);
  import bdlp_pkg::*;

  logic             level_q, level_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             pressed_q, pressed_d;
  logic             lf_q, lf_d;

  logic [TimeW-1:0] diff_chg;
  logic [TimeW-1:0] diff_start;
  logic [TimeW-1:0] hold_diff;
  logic             chg, press, rel;
  logic [1:0]       ev;

  always_comb begin
    diff_chg   = smp_i.now_ms - last_q;
    diff_start = smp_i.now_ms - start_q;
    chg   = (smp_i.pin_level != level_q) &&
            (diff_chg > {{(TimeW-CfgW){1'b0}}, cfg_i.debounce_ms});
    press = chg && !smp_i.pin_level;
    rel   = chg && smp_i.pin_level;

    level_d   = chg ? smp_i.pin_level : level_q;
    last_d    = chg ? smp_i.now_ms : last_q;
    start_d   = press ? smp_i.now_ms : start_q;
    pressed_d = press ? 1'b1 : (rel ? 1'b0 : pressed_q);
    lf_d      = press ? 1'b0 : lf_q;
    ev        = EvNone;

    if (rel && !lf_q) begin
      if (diff_start < {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_ms}) begin
        ev = EvShort;
      end else begin
        ev = EvLong;
      end
    end

    // a press accepted on this sample starts its hold at zero
    hold_diff = press ? '0 : diff_start;
    if (pressed_d && !lf_d &&
        (hold_diff >= {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_ms})) begin
      lf_d = 1'b1;
      ev   = EvLong;
    end

    res_o.press_event  = ev;
    res_o.stable_level = level_d;
    res_o.held         = pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= 1'b1;
      last_q    <= '0;
      start_q   <= '0;
      pressed_q <= 1'b0;
      lf_q      <= 1'b0;
    end else if (adv_i) begin
      level_q   <= level_d;
      last_q    <= last_d;
      start_q   <= start_d;
      pressed_q <= pressed_d;
      lf_q      <= lf_d;
    end
  end

  `BDLP_ASSERT(a_held_matches_level, pressed_q == !level_q, clk_i, rst_ni)
  `BDLP_ASSERT(a_state_holds_when_idle,
    !adv_i |=> $stable({level_q, last_q, start_q, pressed_q, lf_q}), clk_i, rst_ni)
  `BDLP_ASSERT(a_short_only_on_release,
    adv_i && (res_o.press_event == EvShort) |=> !pressed_q && $fell(pressed_q),
    clk_i, rst_ni)
  `BDLP_ASSERT(a_no_bad_code,
    adv_i |-> (res_o.press_event == EvNone || res_o.press_event == EvShort ||
               res_o.press_event == EvLong), clk_i, rst_ni)

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: button debounce long press testbench
// a queue-fed driver offers timestamped button samples with random gaps, a
// monitor takes results under random back-pressure and checks every field
// against a local model of the debouncer; both registers are swept over
// several settings through the apb port, including their extremes
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOff    = 300;
  localparam int unsigned Settle     = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // model of the debouncer
  logic [CfgW-1:0]  m_debounce;
  logic [CfgW-1:0]  m_long_press;
  logic             m_level;
  logic [TimeW-1:0] m_last_chg;
  logic [TimeW-1:0] m_press_start;
  logic             m_pressed;
  logic             m_long_done;

  in_t  sample_q[$];
  out_t expected_q[$];

  logic [TimeW-1:0] gen_t;
  int unsigned n_gen = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_short = 0;
  int unsigned n_long = 0;
  int unsigned n_settings = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  logic calm = 1'b0;
  int unsigned stall_req = 0;
  int unsigned stall_seen = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;

  button_debounce_long_press i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk = ~clk;

  function automatic out_t debounce_predict(in_t smp);
    out_t       res;
    logic [1:0] ev;
    logic [TimeW-1:0] since_chg;
    logic [TimeW-1:0] since_press;
    ev = EvNone;
    since_chg = smp.now_ms - m_last_chg;
    if (smp.pin_level != m_level && since_chg > {16'd0, m_debounce}) begin
      m_level = smp.pin_level;
      m_last_chg = smp.now_ms;
      if (!smp.pin_level) begin
        m_pressed = 1'b1;
        m_press_start = smp.now_ms;
        m_long_done = 1'b0;
      end else begin
        m_pressed = 1'b0;
        if (!m_long_done) begin
          since_press = smp.now_ms - m_press_start;
          ev = (since_press < {16'd0, m_long_press}) ? EvShort : EvLong;
        end
      end
    end
    since_press = smp.now_ms - m_press_start;
    if (m_pressed && !m_long_done && since_press >= {16'd0, m_long_press}) begin
      m_long_done = 1'b1;
      ev = EvLong;
    end
    res.press_event = ev;
    res.stable_level = m_level;
    res.held = m_pressed;
    return res;
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic nxt_valid;
    in_t  nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data = in_data;
      if (in_valid && in_ready) begin
        expected_q.push_back(debounce_predict(in_data));
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!calm && tx_idle_on && $urandom_range(0, 4) == 0) begin
          tx_gap = $urandom_range(0, 11);
        end else if (sample_q.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data = sample_q.pop_front();
        end
      end
      if ($urandom_range(0, 39) == 0) tx_idle_on = !tx_idle_on;
      in_valid <= nxt_valid;
      in_data <= nxt_data;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    out_t want;
    logic nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (out_data.press_event == EvShort) n_short++;
        if (out_data.press_event == EvLong) n_long++;
        if (expected_q.size() == 0) begin
          flag_mismatch("unexpected transaction", 0, 1);
        end else begin
          want = expected_q.pop_front();
          if (out_data.press_event != want.press_event)
            flag_mismatch("press_event", want.press_event, out_data.press_event);
          if (out_data.stable_level != want.stable_level)
            flag_mismatch("stable_level", want.stable_level, out_data.stable_level);
          if (out_data.held != want.held)
            flag_mismatch("held", want.held, out_data.held);
        end
      end
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        rx_hold = HoldOff;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        nxt_ready = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        nxt_ready = 1'b0;
      end else if (!calm && rx_idle_on && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 11);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) rx_idle_on = !rx_idle_on;
      out_ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_sample(logic lvl, logic [TimeW-1:0] t);
    in_t smp;
    smp.pin_level = lvl;
    smp.now_ms = t;
    sample_q.push_back(smp);
    n_gen++;
  endtask

  function automatic logic [TimeW-1:0] near_limit(logic [TimeW-1:0] lim);
    case ($urandom_range(0, 4))
      0: near_limit = (lim == 0) ? '0 : lim - 1;
      1: near_limit = lim;
      2: near_limit = lim + 1;
      default: near_limit = $urandom_range(0, 2 * lim + 2);
    endcase
  endfunction

  task automatic apb_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // read back the same register
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CfgW-1:0] != data[CfgW-1:0])
      flag_mismatch("register readback", data[CfgW-1:0], prdata[CfgW-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(logic [CfgW-1:0] deb, logic [CfgW-1:0] lng);
    apb_write({RegDebounce, 2'b00}, {16'd0, deb});
    m_debounce = deb;
    apb_write({RegLongPress, 2'b00}, {16'd0, lng});
    m_long_press = lng;
    n_settings++;
  endtask

  task automatic wait_drained();
    while (sample_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  // one press and release with bounce on both edges and samples during the hold
  task automatic add_press_cycle();
    logic [TimeW-1:0] t_press;
    logic [TimeW-1:0] hold;
    int unsigned n_mid;
    repeat ($urandom_range(0, 3)) begin
      gen_t += $urandom_range(0, m_debounce);
      push_sample(1'($urandom_range(0, 1)), gen_t);
    end
    gen_t += near_limit(m_debounce);
    push_sample(1'b0, gen_t);
    gen_t += $urandom_range(1, m_debounce + 1);
    push_sample(1'b0, gen_t);
    t_press = gen_t;
    hold = near_limit(m_long_press);
    if ($urandom_range(0, 2) == 0 && hold > m_long_press) begin
      push_sample(1'b0, t_press + m_long_press - 1);
      push_sample(1'b0, t_press + m_long_press);
    end
    n_mid = $urandom_range(0, 5);
    for (int unsigned i = 1; i <= n_mid; i++) begin
      push_sample($urandom_range(0, 7) == 0, t_press + hold * i / (n_mid + 1));
    end
    gen_t = t_press + hold;
    push_sample(1'b1, gen_t);
    repeat ($urandom_range(0, 2)) begin
      gen_t += $urandom_range(0, m_debounce + 1);
      push_sample(1'($urandom_range(0, 1)), gen_t);
    end
    gen_t += near_limit(m_debounce);
    push_sample(1'b1, gen_t);
  endtask

  task automatic add_noise();
    if ($urandom_range(0, 3) == 0) gen_t = $urandom();
    else gen_t += $urandom_range(0, 2 * m_debounce + 2);
    push_sample(1'($urandom_range(0, 1)), gen_t);
  endtask

  task automatic fill_phase(int unsigned quota);
    int unsigned start;
    start = n_gen;
    while (n_gen - start < quota) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_press_cycle();
    end
  endtask

  initial begin : main
    m_debounce = DebounceRst;
    m_long_press = LongPressRst;
    m_level = 1'b1;
    m_last_chg = '0;
    m_press_start = '0;
    m_pressed = 1'b0;
    m_long_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: debounce and long press edges, wrap and backward time
    push_sample(1'b1, 32'd0);
    push_sample(1'b0, 32'd50);
    push_sample(1'b0, 32'd51);
    push_sample(1'b0, 32'd1050);
    push_sample(1'b0, 32'd1051);
    push_sample(1'b0, 32'd2000);
    push_sample(1'b1, 32'd2000);
    push_sample(1'b0, 32'd2030);
    push_sample(1'b0, 32'd2051);
    push_sample(1'b1, 32'd2101);
    push_sample(1'b1, 32'd2102);
    push_sample(1'b0, 32'hffff_fff0);
    push_sample(1'b0, 32'h0000_03d7);
    push_sample(1'b1, 32'h0000_03d8);
    push_sample(1'b0, 32'h0000_0100);
    push_sample(1'b1, 32'h0000_0000);
    push_sample(1'b0, 32'hffff_ffff);
    push_sample(1'b0, 32'h8000_0000);
    push_sample(1'b1, 32'h8000_0033);
    wait_drained();

    gen_t = $urandom();
    set_timing(16'd0, 16'd1);
    fill_phase(200);
    wait_drained();

    set_timing(16'hffff, 16'hffff);
    fill_phase(200);
    wait_drained();

    // zero long press time: fires on the accepting step
    set_timing(16'd0, 16'd0);
    gen_t += 1;
    push_sample(1'b0, gen_t);
    push_sample(1'b1, gen_t + 1);
    fill_phase(150);
    wait_drained();

    repeat (2) begin
      set_timing(CfgW'($urandom_range(0, 300)), CfgW'($urandom_range(1, 3000)));
      fill_phase(200);
      wait_drained();
    end

    // long receiver hold-off, then the sender waits for the pipe to empty
    set_timing(16'd10, 16'd200);
    stall_req <= stall_req + 1;
    fill_phase(150);
    wait_drained();
    fill_phase(150);
    wait_drained();

    calm <= 1'b1;
    set_timing(DebounceRst, LongPressRst);
    fill_phase(200);
    wait_drained();

    err_cnt += expected_q.size();
    $display("%0d samples over %0d register settings, %0d results checked",
             n_accepted, n_settings + 1, n_results);
    $display("%0d short and %0d long presses seen, %0d mismatches",
             n_short, n_long, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
